[rtl/core/dkcr_pkg.sv]
// types and constants shared by the darkness key colour replace block
package dkcr_pkg;

    // sample and register widths
    localparam int unsigned SAMPLE_W  = 8;
    localparam int unsigned DARK_W    = 9;
    localparam int unsigned THRESH_W  = 10;
    localparam int unsigned SOFT_W    = 8;
    localparam int unsigned EDGE_W    = 11;
    localparam int unsigned GAP_W     = 9;
    localparam int unsigned RECIP_W   = 23;
    localparam int unsigned PROD_W    = GAP_W + RECIP_W;
    localparam int unsigned PADDR_W   = 5;
    localparam int unsigned PDATA_W   = 32;

    // ramp reciprocal numerator, 255 << 16
    localparam int unsigned RECIP_NUM = 255 << 16;

    // register reset values
    localparam logic [THRESH_W-1:0] THRESH_RST   = 10'd120;
    localparam logic [SOFT_W-1:0]   SOFT_RST     = 8'd24;
    localparam logic [SAMPLE_W-1:0] KEY_LUMA_RST = 8'd0;
    localparam logic [SAMPLE_W-1:0] KEY_CB_RST   = 8'd128;
    localparam logic [SAMPLE_W-1:0] KEY_CR_RST   = 8'd128;

    // register word index, byte address is four times this
    typedef enum logic [2:0] {
        REG_THRESHOLD     = 3'd0,
        REG_SOFTNESS      = 3'd1,
        REG_KEY_LUMA      = 3'd2,
        REG_KEY_BLUE_DIFF = 3'd3,
        REG_KEY_RED_DIFF  = 3'd4
    } t_reg_idx;

    // incoming pixel request
    typedef struct packed {
        logic [SAMPLE_W-1:0] luma_in;
        logic [SAMPLE_W-1:0] blue_diff_in;
        logic [SAMPLE_W-1:0] red_diff_in;
        logic                frame_end_in;
    } t_pix_in;

    // outgoing blended pixel
    typedef struct packed {
        logic [SAMPLE_W-1:0] luma_out;
        logic [SAMPLE_W-1:0] blue_diff_out;
        logic [SAMPLE_W-1:0] red_diff_out;
        logic                frame_end_out;
    } t_pix_out;

endpackage

[rtl/core/darkness_key_color_replace.sv]
// darkness key with soft edge: five stage pixel pipeline and apb register file
// throughput: one pixel per clock; a full stage holds while the next stage is full and stalled
// the ramp reciprocal comes from a constant table on softness, stored when softness is written
// reset: synchronous active low, empties the pipeline and loads the register reset values
module darkness_key_color_replace
    import dkcr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // pixel requests in
    input  logic               i_valid,
    output logic               o_stall,
    input  t_pix_in            i_data,
    // blended pixels out
    output logic               o_valid,
    input  logic               i_stall,
    output t_pix_out           o_data,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam logic [RECIP_W-1:0] RECIP_RST = RECIP_W'(RECIP_NUM / (2 * SOFT_RST));

    // registers
    logic [THRESH_W-1:0] r_thresh;
    logic [SOFT_W-1:0]   r_soft;
    logic [RECIP_W-1:0]  r_recip;
    logic [SAMPLE_W-1:0] r_key_y;
    logic [SAMPLE_W-1:0] r_key_cb;
    logic [SAMPLE_W-1:0] r_key_cr;

    logic     w_cfg_wr;
    t_reg_idx w_cfg_idx;

    // reciprocal table, one entry per softness value, zero softness never ramps
    logic [RECIP_W-1:0] w_recip_tab [0:255];
    assign w_recip_tab[0] = '0;
    for (genvar s = 1; s < 256; s++) begin : g_recip
        localparam int unsigned RecipVal = RECIP_NUM / (2 * s);
        assign w_recip_tab[s] = RECIP_W'(RecipVal);
    end

    // register write and read decode
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RST;
            r_soft   <= SOFT_RST;
            r_recip  <= RECIP_RST;
            r_key_y  <= KEY_LUMA_RST;
            r_key_cb <= KEY_CB_RST;
            r_key_cr <= KEY_CR_RST;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_THRESHOLD: begin
                    r_thresh <= pwdata[THRESH_W-1:0];
                end
                REG_SOFTNESS: begin
                    r_soft  <= pwdata[SOFT_W-1:0];
                    r_recip <= w_recip_tab[pwdata[SOFT_W-1:0]];
                end
                REG_KEY_LUMA: begin
                    r_key_y <= pwdata[SAMPLE_W-1:0];
                end
                REG_KEY_BLUE_DIFF: begin
                    r_key_cb <= pwdata[SAMPLE_W-1:0];
                end
                REG_KEY_RED_DIFF: begin
                    r_key_cr <= pwdata[SAMPLE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_THRESHOLD:     prdata = PDATA_W'(r_thresh);
            REG_SOFTNESS:      prdata = PDATA_W'(r_soft);
            REG_KEY_LUMA:      prdata = PDATA_W'(r_key_y);
            REG_KEY_BLUE_DIFF: prdata = PDATA_W'(r_key_cb);
            REG_KEY_RED_DIFF:  prdata = PDATA_W'(r_key_cr);
            default:           prdata = '0;
        endcase
    end

    // pipeline valid bits and per stage load enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;

    assign w_en5   = !r_v5 || !i_stall;
    assign w_en4   = !r_v4 || w_en5;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_stall = !w_en1;
    assign o_valid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
            if (w_en5) begin
                r_v5 <= r_v4;
            end
        end
    end

    // stage 1: darkness from luma and chroma offsets
    t_pix_in             r_pix1;
    logic [DARK_W-1:0]   r_dark1;
    logic [SAMPLE_W-1:0] w_mag_cb;
    logic [SAMPLE_W-1:0] w_mag_cr;
    logic [DARK_W-1:0]   n_dark1;

    always_comb begin
        w_mag_cb = i_data.blue_diff_in[7] ? {1'b0, i_data.blue_diff_in[6:0]}
                                          : SAMPLE_W'(9'd128 - {1'b0, i_data.blue_diff_in});
        w_mag_cr = i_data.red_diff_in[7]  ? {1'b0, i_data.red_diff_in[6:0]}
                                          : SAMPLE_W'(9'd128 - {1'b0, i_data.red_diff_in});
        n_dark1  = {1'b0, i_data.luma_in} + {1'b0, w_mag_cb} + {1'b0, w_mag_cr};
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_pix1  <= i_data;
            r_dark1 <= n_dark1;
        end
    end

    // stage 2: place darkness against the ramp edges
    t_pix_in            r_pix2;
    logic               r_zero2;
    logic               r_full2;
    logic [GAP_W-1:0]   r_gap2;
    logic [RECIP_W-1:0] r_recip2;
    logic [EDGE_W-1:0]  w_hi;
    logic [EDGE_W-1:0]  w_dark_x;
    logic [EDGE_W-1:0]  w_gap_x;
    logic               n_zero2;
    logic               n_full2;

    always_comb begin
        w_hi     = EDGE_W'(r_thresh) + EDGE_W'(r_soft);
        w_dark_x = EDGE_W'(r_dark1);
        w_gap_x  = w_hi - w_dark_x;
        n_zero2  = w_dark_x >= w_hi;
        // below threshold - softness, kept unsigned by moving softness across
        n_full2  = !n_zero2 && ((w_dark_x + EDGE_W'(r_soft)) < EDGE_W'(r_thresh));
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_pix2   <= r_pix1;
            r_zero2  <= n_zero2;
            r_full2  <= n_full2;
            r_gap2   <= w_gap_x[GAP_W-1:0];
            r_recip2 <= r_recip;
        end
    end

    // stage 3: ramp product
    t_pix_in           r_pix3;
    logic              r_zero3;
    logic              r_full3;
    logic [PROD_W-1:0] r_prod3;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_pix3  <= r_pix2;
            r_zero3 <= r_zero2;
            r_full3 <= r_full2;
            r_prod3 <= PROD_W'(r_gap2) * PROD_W'(r_recip2);
        end
    end

    // stage 4: key weight and its complement
    t_pix_in             r_pix4;
    logic [SAMPLE_W-1:0] r_t4;
    logic [SAMPLE_W-1:0] r_tinv4;
    logic [SAMPLE_W-1:0] n_t4;

    always_comb begin
        if (r_zero3) begin
            n_t4 = '0;
        end else if (r_full3 || (r_prod3[PROD_W-1:24] != '0)) begin
            n_t4 = '1;
        end else begin
            n_t4 = r_prod3[23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_pix4  <= r_pix3;
            r_t4    <= n_t4;
            r_tinv4 <= ~n_t4;
        end
    end

    // stage 5: blend each component toward the key colour
    t_pix_out r_pix5;
    t_pix_out n_pix5;

    function automatic logic [SAMPLE_W-1:0] mix8(input logic [SAMPLE_W-1:0] a,
                                                 input logic [SAMPLE_W-1:0] b,
                                                 input logic [SAMPLE_W-1:0] w,
                                                 input logic [SAMPLE_W-1:0] winv);
        logic [2*SAMPLE_W:0] sum;
        sum = (2*SAMPLE_W+1)'(a) * (2*SAMPLE_W+1)'(winv)
              + (2*SAMPLE_W+1)'(b) * (2*SAMPLE_W+1)'(w);
        return sum[2*SAMPLE_W-1:SAMPLE_W];
    endfunction

    always_comb begin
        n_pix5.luma_out      = mix8(r_pix4.luma_in, r_key_y, r_t4, r_tinv4);
        n_pix5.blue_diff_out = mix8(r_pix4.blue_diff_in, r_key_cb, r_t4, r_tinv4);
        n_pix5.red_diff_out  = mix8(r_pix4.red_diff_in, r_key_cr, r_t4, r_tinv4);
        n_pix5.frame_end_out = r_pix4.frame_end_in;
    end

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_pix5 <= n_pix5;
        end
    end

    assign o_data = r_pix5;

    // checks on the ramp arithmetic and the reset of the pipeline
    a_ramp_gap_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !r_zero2 && !r_full2 |-> r_gap2 != '0)
        else $error("ramp pixel with zero distance to the upper edge");

    a_ramp_prod_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !r_zero3 && !r_full3 |-> r_prod3[PROD_W-1:24] == '0)
        else $error("ramp product exceeds full weight");

    a_zero_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_zero3 && w_en4 |=> r_t4 == '0 && r_tinv4 == '1)
        else $error("pixel above the ramp did not get zero weight");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_v1 && !r_v4)
        else $error("pipeline not empty after reset");

endmodule
